### rtl/core/scfd_pkg.sv
// Package for the solid color frame detector: widths, register indexes, codes and types.
package scfd_pkg;

  localparam int unsigned FRAME_WIDTH  = 640;
  localparam int unsigned FRAME_HEIGHT = 480;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned COUNT_W = 19;
  localparam int unsigned OTHER_W = 8;
  localparam int unsigned CFG_W   = COUNT_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [OTHER_W-1:0] OTHER_MAX = {OTHER_W{1'b1}};

  localparam logic [COUNT_W-1:0] THRESH_RESET = COUNT_W'(296000);
  localparam logic [OTHER_W-1:0] LIMIT_RESET  = OTHER_W'(50);

  localparam logic [CHAN_W-1:0] CHAN_FULL = {CHAN_W{1'b1}};
  localparam logic [CHAN_W-1:0] CHAN_ZERO = '0;

  typedef enum logic [0:0] {
    REG_MATCH_THRESHOLD = 1'b0,
    REG_OTHER_LIMIT     = 1'b1
  } reg_index_t;

  typedef enum logic [5:0] {
    CLS_WHITE = 6'b000001,
    CLS_RED   = 6'b000010,
    CLS_BLUE  = 6'b000100,
    CLS_GREEN = 6'b001000,
    CLS_BLACK = 6'b010000,
    CLS_OTHER = 6'b100000
  } pix_class_t;

  typedef enum logic [2:0] {
    VERDICT_NONE  = 3'd0,
    VERDICT_WHITE = 3'd1,
    VERDICT_BLACK = 3'd2,
    VERDICT_BLUE  = 3'd3,
    VERDICT_GREEN = 3'd4,
    VERDICT_RED   = 3'd5
  } verdict_t;

endpackage

### rtl/core/solid_color_frame_detector.sv
// Solid color frame detector: classifies BGR pixels, counts classes, reports a verdict per frame.
//
// Takes one pixel per clock while pix_stall is low, for any frame length. A pixel is
// classified in the first register stage; the second stage updates the saturating
// class counters and, on the frame's last pixel, loads the verdict into the result
// register. A result is valid once its last pixel has left the first stage. The input
// stalls only while a last pixel waits in the first stage and the result register
// still holds an earlier verdict that is not taken in that cycle.
module solid_color_frame_detector
  import scfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,

  input  logic               cfg_write,
  input  logic [0:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,

  input  logic               pix_valid,
  output logic               pix_stall,
  input  logic [CHAN_W-1:0]  pix_blue,
  input  logic [CHAN_W-1:0]  pix_green,
  input  logic [CHAN_W-1:0]  pix_red,
  input  logic               frame_end,

  output logic               res_valid,
  input  logic               res_stall,
  output logic [2:0]         verdict,
  output logic               rejected
);

  logic [COUNT_W-1:0] match_threshold;
  logic [OTHER_W-1:0] other_limit;

  logic               a_valid;
  logic               a_last;
  pix_class_t         a_class;
  pix_class_t         a_class_next;

  logic [COUNT_W-1:0] white_count, black_count, blue_count, green_count, red_count;
  logic [COUNT_W-1:0] white_count_next, black_count_next, blue_count_next;
  logic [COUNT_W-1:0] green_count_next, red_count_next;
  logic [OTHER_W-1:0] other_count, other_count_next;

  logic               a_load;
  logic               b_go;
  logic               b_emit;
  logic               res_free;
  verdict_t           verdict_next;
  logic               rejected_next;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      match_threshold <= THRESH_RESET;
      other_limit     <= LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MATCH_THRESHOLD: match_threshold <= cfg_data;
        REG_OTHER_LIMIT:     other_limit     <= cfg_data[OTHER_W-1:0];
        default: ;
      endcase
    end
  end

  // flow control
  assign res_free  = !res_valid || !res_stall;
  assign b_go      = a_valid && (!a_last || res_free);
  assign b_emit    = b_go && a_last;
  assign a_load    = !a_valid || b_go;
  assign pix_stall = !a_load;

  // stage A: classify
  always_comb begin
    if (pix_blue == CHAN_FULL && pix_green == CHAN_FULL && pix_red == CHAN_FULL) begin
      a_class_next = CLS_WHITE;
    end else if (pix_blue == CHAN_ZERO && pix_green == CHAN_ZERO && pix_red == CHAN_FULL) begin
      a_class_next = CLS_RED;
    end else if (pix_blue == CHAN_FULL && pix_green == CHAN_ZERO && pix_red == CHAN_ZERO) begin
      a_class_next = CLS_BLUE;
    end else if (pix_blue == CHAN_ZERO && pix_green == CHAN_FULL && pix_red == CHAN_ZERO) begin
      a_class_next = CLS_GREEN;
    end else if (pix_blue == CHAN_ZERO && pix_green == CHAN_ZERO && pix_red == CHAN_ZERO) begin
      a_class_next = CLS_BLACK;
    end else begin
      a_class_next = CLS_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_load) begin
      a_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load && pix_valid) begin
      a_class <= a_class_next;
      a_last  <= frame_end;
    end
  end

  // stage B: saturating counts including the current pixel
  always_comb begin
    white_count_next = white_count;
    black_count_next = black_count;
    blue_count_next  = blue_count;
    green_count_next = green_count;
    red_count_next   = red_count;
    other_count_next = other_count;
    case (a_class)
      CLS_WHITE: if (white_count != COUNT_MAX) white_count_next = white_count + 1'b1;
      CLS_BLACK: if (black_count != COUNT_MAX) black_count_next = black_count + 1'b1;
      CLS_BLUE:  if (blue_count  != COUNT_MAX) blue_count_next  = blue_count  + 1'b1;
      CLS_GREEN: if (green_count != COUNT_MAX) green_count_next = green_count + 1'b1;
      CLS_RED:   if (red_count   != COUNT_MAX) red_count_next   = red_count   + 1'b1;
      CLS_OTHER: if (other_count != OTHER_MAX) other_count_next = other_count + 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    rejected_next = 1'b0;
    verdict_next  = VERDICT_NONE;
    if (other_count_next > other_limit) begin
      rejected_next = 1'b1;
    end else if (white_count_next >= match_threshold) begin
      verdict_next = VERDICT_WHITE;
    end else if (black_count_next >= match_threshold) begin
      verdict_next = VERDICT_BLACK;
    end else if (blue_count_next >= match_threshold) begin
      verdict_next = VERDICT_BLUE;
    end else if (green_count_next >= match_threshold) begin
      verdict_next = VERDICT_GREEN;
    end else if (red_count_next >= match_threshold) begin
      verdict_next = VERDICT_RED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || b_emit) begin
      white_count <= '0;
      black_count <= '0;
      blue_count  <= '0;
      green_count <= '0;
      red_count   <= '0;
      other_count <= '0;
    end else if (b_go) begin
      white_count <= white_count_next;
      black_count <= black_count_next;
      blue_count  <= blue_count_next;
      green_count <= green_count_next;
      red_count   <= red_count_next;
      other_count <= other_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= b_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (b_emit) begin
      verdict  <= verdict_next;
      rejected <= rejected_next;
    end
  end

  // checks
  a_counts_clear: assert property (@(posedge clk) disable iff (rst)
    b_emit |=> (white_count == '0 && black_count == '0 && blue_count == '0 &&
                green_count == '0 && red_count == '0 && other_count == '0))
    else $error("counters not cleared after frame end");

  a_reject_none: assert property (@(posedge clk) disable iff (rst)
    (res_valid && rejected) |-> (verdict == VERDICT_NONE))
    else $error("rejected frame carries a color verdict");

  a_class_onehot: assert property (@(posedge clk) disable iff (rst)
    a_valid |-> $onehot(a_class))
    else $error("pixel class not one-hot");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> (a_valid && a_last && res_valid && res_stall))
    else $error("input stalled without a blocked frame end");

endmodule
